### src/psj_pkg.sv
// Shared types and constants for the tolerant point-set Jaccard block.
`timescale 1ns / 1ps
`default_nettype none
package psj_pkg;

  localparam int COORD_W   = 32;
  localparam int TOL_W     = 16;
  localparam int MATCH_W   = 21;
  localparam int SIM_W     = 17;
  localparam int FRAC_W    = 16;
  localparam int UNION_MAX = 1048575;
  localparam int UNION_MIN = -1048576;

  localparam logic [TOL_W-1:0]   TOL_RESET = 16'd66;
  localparam logic [MATCH_W-1:0] MATCH_CAP = 21'h1FFFFF;
  localparam logic [SIM_W-1:0]   Q16_ONE   = 17'h10000;

  typedef struct packed {
    logic signed [COORD_W-1:0] x;
    logic signed [COORD_W-1:0] y;
    logic signed [COORD_W-1:0] z;
  } point_t;

endpackage
`default_nettype wire

### src/psj_store.sv
// First-set point memory: one write port, one registered read port.
`timescale 1ns / 1ps
`default_nettype none
module psj_store #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  wire logic            clk_i,
  input  wire logic            wr_en_i,
  input  wire logic [AW-1:0]   wr_addr_i,
  input  psj_pkg::point_t      wr_data_i,
  input  wire logic            rd_en_i,
  input  wire logic [AW-1:0]   rd_addr_i,
  output psj_pkg::point_t      rd_data_o
);

  psj_pkg::point_t mem_q [DEPTH];
  psj_pkg::point_t rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule
`default_nettype wire

### src/psj_cmp.sv
// Per-axis strict tolerance compare of a stored point against the query point.
`timescale 1ns / 1ps
`default_nettype none
module psj_cmp (
  input  psj_pkg::point_t                    stored_i,
  input  psj_pkg::point_t                    query_i,
  input  wire logic [psj_pkg::TOL_W-1:0]     tol_i,
  output logic                               hit_o
);

  localparam int DW = psj_pkg::COORD_W + 1;

  function automatic logic axis_close(input logic signed [psj_pkg::COORD_W-1:0] a,
                                      input logic signed [psj_pkg::COORD_W-1:0] b,
                                      input logic [psj_pkg::TOL_W-1:0] tol);
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] t;
    d = DW'(a) - DW'(b);
    t = $signed(DW'(tol));
    axis_close = (d < t) && (d > -t);
  endfunction

  assign hit_o = axis_close(stored_i.x, query_i.x, tol_i) &&
                 axis_close(stored_i.y, query_i.y, tol_i) &&
                 axis_close(stored_i.z, query_i.z, tol_i);

endmodule
`default_nettype wire

### src/psj_div.sv
// Restoring divider: 16 fraction bits of num/den, one bit per cycle, num < den.
`timescale 1ns / 1ps
`default_nettype none
module psj_div #(
  parameter int W = 22
) (
  input  wire logic                        clk_i,
  input  wire logic                        rst_ni,
  input  wire logic                        start_i,
  input  wire logic [W-1:0]                num_i,
  input  wire logic [W-1:0]                den_i,
  output logic                             done_o,
  output logic [psj_pkg::FRAC_W-1:0]       quot_o
);

  localparam int CNT_W = $clog2(psj_pkg::FRAC_W + 1);

  logic [W:0]                    rem_q, rem_d;
  logic [W-1:0]                  den_q;
  logic [psj_pkg::FRAC_W-1:0]    quot_q, quot_d;
  logic [CNT_W-1:0]              cnt_q, cnt_d;
  logic                          done_q, done_d;
  logic [W:0]                    rem_sh;
  logic                          ge;

  assign rem_sh = {rem_q[W-1:0], 1'b0};
  assign ge     = rem_sh >= {1'b0, den_q};

  always_comb begin
    rem_d  = rem_q;
    quot_d = quot_q;
    cnt_d  = cnt_q;
    done_d = 1'b0;
    if (start_i) begin
      rem_d  = {1'b0, num_i};
      quot_d = '0;
      cnt_d  = CNT_W'(psj_pkg::FRAC_W);
    end else if (cnt_q != '0) begin
      rem_d  = ge ? rem_sh - {1'b0, den_q} : rem_sh;
      quot_d = {quot_q[psj_pkg::FRAC_W-2:0], ge};
      cnt_d  = cnt_q - 1'b1;
      done_d = (cnt_q == CNT_W'(1));
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q  <= '0;
      done_q <= 1'b0;
    end else begin
      cnt_q  <= cnt_d;
      done_q <= done_d;
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q  <= rem_d;
    quot_q <= quot_d;
    if (start_i) begin
      den_q <= den_i;
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule
`default_nettype wire

### src/point_set_tolerant_jaccard_top.sv
// Top level: sequencer, counters and result register of the tolerant Jaccard block.
// Load word (mode 0): busy stays low, so the next word may follow at once.
// Compare word (mode 1): busy through scan, drain and tail, with one store read per cycle in scan;
// the scan and drain are skipped when the first set is empty or the second set is full.
// Last compare word may also run the bit-serial divider; strobe follows next cycle.
// Reset clears counters and flags and sets tolerance to 66; the store holds no state until written.
`timescale 1ns / 1ps
`default_nettype none
module point_set_tolerant_jaccard_top #(
  parameter int MAX_POINTS = 1024
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 start,
  output logic                                      busy,
  input  wire logic                                 mode_i,
  input  wire logic signed [psj_pkg::COORD_W-1:0]   coord_x_i,
  input  wire logic signed [psj_pkg::COORD_W-1:0]   coord_y_i,
  input  wire logic signed [psj_pkg::COORD_W-1:0]   coord_z_i,
  input  wire logic                                 last_point_i,
  input  wire logic                                 cfg_valid_i,
  output logic                                      cfg_ready_o,
  input  wire logic [psj_pkg::TOL_W-1:0]            cfg_data_i,
  output logic                                      res_valid_o,
  output logic [psj_pkg::MATCH_W-1:0]               matches_res_o,
  output logic signed [psj_pkg::MATCH_W-1:0]        union_size_o,
  output logic [psj_pkg::SIM_W-1:0]                 similarity_o,
  output logic                                      ratio_degenerate_o,
  output logic                                      set_overflow_o
);

  localparam int CW = $clog2(MAX_POINTS + 1);
  localparam int AW = $clog2(MAX_POINTS);
  localparam int MW = psj_pkg::MATCH_W;
  localparam int UW = ((CW + 1 > MW) ? CW + 1 : MW) + 1;
  localparam logic [CW-1:0] MAX_CNT = CW'(MAX_POINTS);
  localparam logic signed [UW-1:0] U_MAX = UW'(psj_pkg::UNION_MAX);
  localparam logic signed [UW-1:0] U_MIN = UW'(psj_pkg::UNION_MIN);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_DRAIN = 3'd2;
  localparam logic [2:0] S_TAIL  = 3'd3;
  localparam logic [2:0] S_DIV   = 3'd4;

  logic [2:0]                  state_q, state_d;
  logic [CW-1:0]               first_cnt_q, first_cnt_d;
  logic [CW-1:0]               second_cnt_q, second_cnt_d;
  logic [CW-1:0]               idx_q, idx_d;
  logic [MW-1:0]               match_q, match_d;
  logic                        ovf_q, ovf_d;
  logic [psj_pkg::TOL_W-1:0]   tol_q;
  psj_pkg::point_t             qry_q;
  logic                        last_q;
  logic                        rd_vld_q;
  logic                        hit_q, hit_vld_q;

  logic                        res_valid_q, res_valid_d;
  logic [MW-1:0]               res_match_q, res_match_d;
  logic [MW-1:0]               res_union_q, res_union_d;
  logic [psj_pkg::SIM_W-1:0]   res_sim_q, res_sim_d;
  logic                        res_degen_q, res_degen_d;
  logic                        res_ovf_q, res_ovf_d;

  logic                        accept;
  logic                        wr_en;
  logic                        rd_en;
  psj_pkg::point_t             in_pt;
  psj_pkg::point_t             rd_pt;
  logic                        cmp_hit;
  logic                        div_start;
  logic                        div_done;
  logic [psj_pkg::FRAC_W-1:0]  div_quot;
  logic signed [UW-1:0]        uni_c;
  logic signed [UW-1:0]        uni_sat;
  logic signed [UW-1:0]        match_s;

  assign busy        = (state_q != S_IDLE);
  assign accept      = start && !busy;
  assign cfg_ready_o = 1'b1;

  assign in_pt.x = coord_x_i;
  assign in_pt.y = coord_y_i;
  assign in_pt.z = coord_z_i;

  assign wr_en = accept && !mode_i && (first_cnt_q < MAX_CNT);
  assign rd_en = (state_q == S_SCAN);

  psj_store #(
    .DEPTH (MAX_POINTS),
    .AW    (AW)
  ) u_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (first_cnt_q[AW-1:0]),
    .wr_data_i (in_pt),
    .rd_en_i   (rd_en),
    .rd_addr_i (idx_q[AW-1:0]),
    .rd_data_o (rd_pt)
  );

  psj_cmp u_cmp (
    .stored_i (rd_pt),
    .query_i  (qry_q),
    .tol_i    (tol_q),
    .hit_o    (cmp_hit)
  );

  psj_div #(
    .W (UW - 1)
  ) u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (div_start),
    .num_i   ((UW-1)'(match_q)),
    .den_i   (uni_c[UW-2:0]),
    .done_o  (div_done),
    .quot_o  (div_quot)
  );

  assign match_s = $signed(UW'(match_q));
  assign uni_c   = $signed(UW'(first_cnt_q)) + $signed(UW'(second_cnt_q)) - match_s;

  always_comb begin
    if (uni_c > U_MAX) begin
      uni_sat = U_MAX;
    end else if (uni_c < U_MIN) begin
      uni_sat = U_MIN;
    end else begin
      uni_sat = uni_c;
    end
  end

  always_comb begin
    state_d      = state_q;
    first_cnt_d  = first_cnt_q;
    second_cnt_d = second_cnt_q;
    idx_d        = idx_q;
    match_d      = match_q;
    ovf_d        = ovf_q;
    res_valid_d  = 1'b0;
    res_match_d  = res_match_q;
    res_union_d  = res_union_q;
    res_sim_d    = res_sim_q;
    res_degen_d  = res_degen_q;
    res_ovf_d    = res_ovf_q;
    div_start    = 1'b0;

    // count a hit from the compare stage, saturating
    if (hit_vld_q && hit_q && (match_q != psj_pkg::MATCH_CAP)) begin
      match_d = match_q + 1'b1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          if (!mode_i) begin
            if (first_cnt_q < MAX_CNT) begin
              first_cnt_d = first_cnt_q + 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end else begin
            idx_d = '0;
            if (second_cnt_q < MAX_CNT) begin
              second_cnt_d = second_cnt_q + 1'b1;
              state_d      = (first_cnt_q != '0) ? S_SCAN : S_TAIL;
            end else begin
              ovf_d   = 1'b1;
              state_d = S_TAIL;
            end
          end
        end
      end
      S_SCAN: begin
        idx_d = idx_q + 1'b1;
        if (CW'(idx_q + 1'b1) == first_cnt_q) begin
          state_d = S_DRAIN;
        end
      end
      S_DRAIN: begin
        // wait until the read and compare stages are empty
        if (!rd_vld_q && !hit_vld_q) begin
          state_d = S_TAIL;
        end
      end
      S_TAIL: begin
        if (!last_q) begin
          state_d = S_IDLE;
        end else begin
          res_match_d = match_q;
          res_union_d = uni_sat[MW-1:0];
          res_ovf_d   = ovf_q;
          if (uni_c <= 0) begin
            res_sim_d   = '0;
            res_degen_d = 1'b1;
          end else if (match_s > uni_c) begin
            res_sim_d   = psj_pkg::Q16_ONE;
            res_degen_d = 1'b1;
          end else if (match_s == uni_c) begin
            res_sim_d   = psj_pkg::Q16_ONE;
            res_degen_d = 1'b0;
          end else begin
            div_start = 1'b1;
          end
          if (div_start) begin
            state_d = S_DIV;
          end else begin
            res_valid_d  = 1'b1;
            first_cnt_d  = '0;
            second_cnt_d = '0;
            match_d      = '0;
            ovf_d        = 1'b0;
            state_d      = S_IDLE;
          end
        end
      end
      S_DIV: begin
        if (div_done) begin
          res_sim_d    = {1'b0, div_quot};
          res_degen_d  = 1'b0;
          res_valid_d  = 1'b1;
          first_cnt_d  = '0;
          second_cnt_d = '0;
          match_d      = '0;
          ovf_d        = 1'b0;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      first_cnt_q  <= '0;
      second_cnt_q <= '0;
      idx_q        <= '0;
      match_q      <= '0;
      ovf_q        <= 1'b0;
      tol_q        <= psj_pkg::TOL_RESET;
      rd_vld_q     <= 1'b0;
      hit_vld_q    <= 1'b0;
      res_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      first_cnt_q  <= first_cnt_d;
      second_cnt_q <= second_cnt_d;
      idx_q        <= idx_d;
      match_q      <= match_d;
      ovf_q        <= ovf_d;
      rd_vld_q     <= rd_en;
      hit_vld_q    <= rd_vld_q;
      res_valid_q  <= res_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    hit_q       <= cmp_hit;
    res_match_q <= res_match_d;
    res_union_q <= res_union_d;
    res_sim_q   <= res_sim_d;
    res_degen_q <= res_degen_d;
    res_ovf_q   <= res_ovf_d;
    if (accept && mode_i) begin
      qry_q  <= in_pt;
      last_q <= last_point_i;
    end
  end

  assign res_valid_o        = res_valid_q;
  assign matches_res_o      = res_match_q;
  assign union_size_o       = $signed(res_union_q);
  assign similarity_o       = res_sim_q;
  assign ratio_degenerate_o = res_degen_q;
  assign set_overflow_o     = res_ovf_q;

  a_strobe_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o)
    else $error("result strobe held longer than one cycle");

  a_sim_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (similarity_o <= psj_pkg::Q16_ONE))
    else $error("similarity above one");

  a_union_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && !ratio_degenerate_o) |-> (union_size_o > 0))
    else $error("non-degenerate result with union not positive");

  a_cmp_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy && mode_i) |=> busy)
    else $error("compare word taken without going busy");

endmodule
`default_nettype wire
